// ----- hdl/tsw_pkg.sv -----
package tsw_pkg;

    localparam int SEQ_W  = 16;
    localparam int LEN_W  = 12;
    localparam int TIME_W = 32;
    localparam int WIN_W  = 24;

    localparam logic [WIN_W-1:0] MAX24 = 24'hFFFFFF;

    // Register values after reset
    localparam logic [15:0] RST_INIT_CWND = 16'd1024;
    localparam logic [23:0] RST_INIT_SS   = 24'd15360;
    localparam logic [11:0] RST_MSS       = 12'd1024;
    localparam logic [15:0] RST_RTO       = 16'd500;
    localparam logic [15:0] RST_START_SEQ = 16'd0;

    // Configuration register indexes
    localparam logic [2:0] CFG_INIT_CWND = 3'd0;
    localparam logic [2:0] CFG_INIT_SS   = 3'd1;
    localparam logic [2:0] CFG_MSS       = 3'd2;
    localparam logic [2:0] CFG_RTO       = 3'd3;
    localparam logic [2:0] CFG_START_SEQ = 3'd4;

    typedef enum logic [1:0] {
        K_PUSH = 2'd0,
        K_ACK  = 2'd1,
        K_TICK = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RK_SEND   = 3'd0,
        RK_RETX   = 3'd1,
        RK_REFUSE = 3'd2,
        RK_ACK    = 3'd3,
        RK_TICK   = 3'd4
    } t_rkind;

    typedef enum logic [1:0] {
        CC_SS = 2'd0,
        CC_DN = 2'd1,
        CC_FR = 2'd2,
        CC_CA = 2'd3
    } t_cc;

    typedef struct packed {
        logic             go;
        logic [WIN_W-1:0] num;
        logic [WIN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [WIN_W-1:0] quo;
    } t_div_rsp;

    function automatic logic [WIN_W-1:0] f_sat24(input logic [WIN_W:0] v);
        return v[WIN_W] ? MAX24 : v[WIN_W-1:0];
    endfunction

    // Reduces x modulo m by shifted compare and subtract; x below 128 * m.
    function automatic logic [16:0] f_mod_seq(input logic [16:0] x, input logic [16:0] m);
        logic [23:0] r;
        logic [23:0] mk;
        r = {7'd0, x};
        for (int k = 6; k >= 0; k--) begin
            mk = {7'd0, m} << k;
            if (r >= mk) begin
                r = r - mk;
            end
        end
        return r[16:0];
    endfunction

endpackage

// ----- hdl/tcp_sender_window_congestion_core.sv -----
// A push gives its single result in the cycle after acceptance, and busy stays low.
// An ACK keeps the block busy for a pipelined window scan, then for a fast retransmit
// pass or the avoidance division when one is needed; a tick runs a detection scan and an
// emit scan of the window. Each final result appears in the cycle in which busy falls.
// Throughput is set by the one-read-port entry memory, one window entry per cycle per pass.
// Synchronous active-low reset loads the register defaults and clears all entry flags.
// Results are strobed for a single cycle; the receiver cannot stall them.
module tcp_sender_window_congestion_core #(
    parameter int WINDOW_ENTRIES = 16,
    parameter int SEQ_SPACE      = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_seg_len,
    input  logic [15:0] i_ack_num,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_res_valid,
    output logic [2:0]  o_result_kind,
    output logic [15:0] o_seq,
    output logic [11:0] o_len,
    output logic        o_is_dup,
    output logic [23:0] o_cwnd_out,
    output logic [23:0] o_ssthresh_out,
    output logic [1:0]  o_cc_state,
    output logic [4:0]  o_window_pkts,
    output logic [23:0] o_window_bytes,
    output logic        o_last
);

    import tsw_pkg::*;

    localparam int          IW   = $clog2(WINDOW_ENTRIES);
    localparam int          CW   = $clog2(WINDOW_ENTRIES + 1);
    localparam logic [16:0] SSP  = 17'(SEQ_SPACE);
    localparam logic [16:0] HALF = 17'(SEQ_SPACE / 2);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_ASCAN  = 10'b00_0000_0010,
        ST_AFIN   = 10'b00_0000_0100,
        ST_FRSCAN = 10'b00_0000_1000,
        ST_FRHEAD = 10'b00_0001_0000,
        ST_DIV    = 10'b00_0010_0000,
        ST_TSCAN  = 10'b00_0100_0000,
        ST_TUPD   = 10'b00_1000_0000,
        ST_TEMIT  = 10'b01_0000_0000,
        ST_STAT   = 10'b10_0000_0000
    } t_st;

    // Ring slot of the k-th entry counted from the head.
    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= (CW+1)'(WINDOW_ENTRIES)) begin
            s = s - (CW+1)'(WINDOW_ENTRIES);
        end
        return s[IW-1:0];
    endfunction

    // Forward distance from b to a in sequence space.
    function automatic logic [16:0] f_dist(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] d;
        d = {1'b0, a} + SSP - {1'b0, b};
        if (d >= SSP) begin
            d = d - SSP;
        end
        return d;
    endfunction

    // Configuration
    logic [15:0] r_init_cwnd;
    logic [11:0] r_mss;
    logic [15:0] r_rto;

    // Window and congestion state
    t_st             r_st;
    logic [15:0]     r_next_seq;
    logic [IW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic [23:0]     r_bytes;
    logic [23:0]     r_cwnd;
    logic [23:0]     r_ss;
    t_cc             r_cur;
    t_cc             r_prev;
    logic [1:0]      r_dupc;
    logic [WINDOW_ENTRIES-1:0] r_sent;
    logic [WINDOW_ENTRIES-1:0] r_acked;

    // Per-item working registers
    logic [15:0]     r_ack;
    logic [31:0]     r_now;
    logic            r_is_tick;
    logic            r_dup;
    logic            r_abort;
    logic            r_found;
    logic            r_pop;
    logic [CW-1:0]   r_npop;
    logic            r_timed;

    // Scan pipeline: address issue, then data in the following cycle
    logic [CW-1:0]   r_i;
    logic            r_pv;
    logic [IW-1:0]   r_ps;
    logic            r_pfirst;

    // Result registers
    logic            r_o_valid;
    logic [2:0]      r_o_kind;
    logic [15:0]     r_o_seq;
    logic [11:0]     r_o_len;
    logic            r_o_dup;
    logic            r_o_last;

    logic            w_scan;
    logic            w_issue;
    logic            w_scan_done;
    logic [IW-1:0]   w_slot_i;
    logic [IW-1:0]   w_tail;
    logic [15:0]     w_rd_seq;
    logic [11:0]     w_rd_len;
    logic [31:0]     w_rd_tim;
    logic [16:0]     w_end17;
    logic [15:0]     w_end;
    logic [16:0]     w_dist;
    logic            w_after;
    logic            w_before;
    logic            w_match;
    logic            w_acked_i;
    logic            w_ok;
    logic            w_tout;
    logic            w_fr_head;
    logic            w_fr_emit;
    logic            w_t_emit;
    logic            w_push_ok;
    logic [16:0]     w_nseq17;
    logic [16:0]     w_ack17;
    logic [16:0]     w_cfg_seq17;
    logic            w_dup;
    logic [CW:0]     w_head_sum;
    logic [IW-1:0]   w_head_new;
    logic [1:0]      w_dupc_inc;
    t_cc             w_restore;
    logic [23:0]     w_half;
    logic [23:0]     w_ss_new;
    logic [13:0]     w_mss3;
    logic [23:0]     w_ss_grow;
    logic [23:0]     w_mss_sq;
    logic            w_mem_dat_en;
    logic            w_mem_tim_en;
    logic [IW-1:0]   w_mem_addr;
    logic [31:0]     w_mem_tim;
    logic            w_emit;
    t_rkind          w_emit_kind;
    logic [15:0]     w_emit_seq;
    logic [11:0]     w_emit_len;
    logic            w_emit_dup;
    logic            w_emit_last;
    t_div_req        w_div_req;
    t_div_rsp        w_div_rsp;

    assign busy        = (r_st != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Scan pipeline. Every pass walks the window from the head, issuing one
    // memory read per cycle; the entry is evaluated when its data returns.
    // ------------------------------------------------------------------
    assign w_scan      = (r_st == ST_ASCAN) || (r_st == ST_FRSCAN) ||
                         (r_st == ST_TSCAN) || (r_st == ST_TEMIT);
    assign w_issue     = w_scan && (r_i != r_count);
    assign w_scan_done = w_scan && (r_i == r_count) && !r_pv;
    assign w_slot_i    = f_slot(r_head, r_i);
    assign w_tail      = f_slot(r_head, r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i  <= '0;
            r_pv <= 1'b0;
        end else if (!w_scan) begin
            r_i  <= '0;
            r_pv <= 1'b0;
        end else begin
            r_pv     <= w_issue;
            r_ps     <= w_slot_i;
            r_pfirst <= (r_i == '0);
            if (w_issue) begin
                r_i <= r_i + CW'(1);
            end
        end
    end

    // Per-entry evaluation on the returned data
    assign w_end17   = f_mod_seq({1'b0, w_rd_seq} + {5'd0, w_rd_len}, SSP);
    assign w_end     = w_end17[15:0];
    assign w_dist    = f_dist(w_end, r_ack);
    assign w_after   = (w_dist != '0) && (w_dist < HALF);
    assign w_before  = (w_dist != '0) && (w_dist >= HALF);
    assign w_match   = (w_end == r_ack) && !r_found;
    assign w_acked_i = r_acked[r_ps] || w_match;
    // The first entry decides whether the ACK can free anything at all.
    assign w_ok      = r_pfirst ? !w_after : !r_abort;
    assign w_tout    = (r_now - w_rd_tim) >= {16'd0, r_rto};
    // Fast retransmit: a head ending beyond the ACK is resent alone.
    assign w_fr_head = r_pfirst && w_after;
    assign w_fr_emit = !r_abort && (w_fr_head || (!r_acked[r_ps] && w_before));
    assign w_t_emit  = !r_acked[r_ps] && (!r_sent[r_ps] || w_tout);

    // Item-level arithmetic
    assign w_push_ok   = (r_bytes < r_cwnd) && (r_count < CW'(WINDOW_ENTRIES));
    assign w_nseq17    = f_mod_seq({1'b0, r_next_seq} + {5'd0, i_seg_len}, SSP);
    assign w_ack17     = f_mod_seq({1'b0, i_ack_num}, SSP);
    assign w_cfg_seq17 = f_mod_seq({1'b0, i_cfg_data[15:0]}, SSP);
    assign w_dup       = (r_npop == '0);
    assign w_head_sum  = (CW+1)'(r_head) + (CW+1)'(r_npop);
    assign w_head_new  = (w_head_sum >= (CW+1)'(WINDOW_ENTRIES)) ?
                         IW'(w_head_sum - (CW+1)'(WINDOW_ENTRIES)) : IW'(w_head_sum);
    assign w_dupc_inc  = r_dupc + 2'd1;
    assign w_restore   = (r_cur == CC_DN) ? r_prev : r_cur;
    assign w_half      = {1'b0, r_cwnd[23:1]};
    assign w_ss_new    = (w_half > {8'd0, r_init_cwnd}) ? w_half : {8'd0, r_init_cwnd};
    assign w_mss3      = {1'b0, r_mss, 1'b0} + {2'd0, r_mss};
    assign w_ss_grow   = f_sat24({1'b0, w_ss_new} + {11'd0, w_mss3});
    assign w_mss_sq    = {12'd0, r_mss} * {12'd0, r_mss};

    // The avoidance step divides mss squared by cwnd, with zero taken as one.
    assign w_div_req.go  = (r_st == ST_AFIN) && w_dup == 1'b0 && (w_restore == CC_CA);
    assign w_div_req.num = w_mss_sq;
    assign w_div_req.den = (r_cwnd == '0) ? 24'd1 : r_cwnd;

    // ------------------------------------------------------------------
    // Entry memory write port and result selection
    // ------------------------------------------------------------------
    always_comb begin
        w_mem_dat_en = 1'b0;
        w_mem_tim_en = 1'b0;
        w_mem_addr   = r_ps;
        w_mem_tim    = r_now;
        w_emit       = 1'b0;
        w_emit_kind  = RK_SEND;
        w_emit_seq   = '0;
        w_emit_len   = '0;
        w_emit_dup   = 1'b0;
        w_emit_last  = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (start && (i_kind == K_PUSH)) begin
                    w_emit      = 1'b1;
                    w_emit_last = 1'b1;
                    if (w_push_ok) begin
                        w_mem_dat_en = 1'b1;
                        w_mem_tim_en = 1'b1;
                        w_mem_addr   = w_tail;
                        w_mem_tim    = i_now_ms;
                        w_emit_kind  = RK_SEND;
                        w_emit_seq   = r_next_seq;
                        w_emit_len   = i_seg_len;
                    end else begin
                        w_emit_kind = RK_REFUSE;
                    end
                end
            end
            ST_FRSCAN: begin
                if (r_pv && w_fr_emit) begin
                    w_emit       = 1'b1;
                    w_emit_kind  = RK_RETX;
                    w_emit_seq   = w_rd_seq;
                    w_emit_len   = w_rd_len;
                    w_emit_dup   = 1'b1;
                    w_mem_tim_en = !w_fr_head;
                end
            end
            ST_FRHEAD: begin
                w_mem_tim_en = 1'b1;
                w_mem_addr   = r_head;
            end
            ST_TEMIT: begin
                if (r_pv && w_t_emit) begin
                    w_emit       = 1'b1;
                    w_emit_kind  = r_sent[r_ps] ? RK_RETX : RK_SEND;
                    w_emit_seq   = w_rd_seq;
                    w_emit_len   = w_rd_len;
                    w_mem_tim_en = 1'b1;
                end
            end
            ST_STAT: begin
                w_emit      = 1'b1;
                w_emit_kind = r_is_tick ? RK_TICK : RK_ACK;
                w_emit_dup  = r_dup;
                w_emit_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_init_cwnd <= RST_INIT_CWND;
            r_mss       <= RST_MSS;
            r_rto       <= RST_RTO;
            r_next_seq  <= RST_START_SEQ;
            r_head      <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_cwnd      <= {8'd0, RST_INIT_CWND};
            r_ss        <= RST_INIT_SS;
            r_cur       <= CC_SS;
            r_prev      <= CC_SS;
            r_dupc      <= '0;
            r_sent      <= '0;
            r_acked     <= '0;
            r_dup       <= 1'b0;
            r_is_tick   <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (start) begin
                        r_now   <= i_now_ms;
                        r_ack   <= w_ack17[15:0];
                        r_abort <= 1'b0;
                        r_found <= 1'b0;
                        r_pop   <= 1'b1;
                        r_npop  <= '0;
                        r_timed <= 1'b0;
                        unique case (i_kind)
                            K_PUSH: begin
                                if (w_push_ok) begin
                                    r_sent[w_tail]  <= 1'b1;
                                    r_acked[w_tail] <= 1'b0;
                                    r_next_seq      <= w_nseq17[15:0];
                                    r_count         <= r_count + CW'(1);
                                    r_bytes <= f_sat24({1'b0, r_bytes} + {13'd0, i_seg_len});
                                end
                            end
                            K_ACK: begin
                                r_is_tick <= 1'b0;
                                r_st      <= ST_ASCAN;
                            end
                            K_TICK: begin
                                r_is_tick <= 1'b1;
                                r_dup     <= 1'b0;
                                r_st      <= ST_TSCAN;
                            end
                            K_NONE: begin
                            end
                        endcase
                    end
                end
                ST_ASCAN: begin
                    // Mark the entry ending at the ACK and retire the acked prefix.
                    if (r_pv && w_ok) begin
                        if (w_match) begin
                            r_found <= 1'b1;
                        end
                        if (r_pop && w_acked_i) begin
                            r_bytes <= ({12'd0, w_rd_len} > r_bytes) ? '0 :
                                       r_bytes - {12'd0, w_rd_len};
                            r_sent[r_ps]  <= 1'b0;
                            r_acked[r_ps] <= 1'b0;
                            r_npop        <= r_npop + CW'(1);
                        end else begin
                            r_pop <= 1'b0;
                            if (w_match) begin
                                r_acked[r_ps] <= 1'b1;
                            end
                        end
                    end
                    if (r_pv && r_pfirst && w_after) begin
                        r_abort <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_st <= ST_AFIN;
                    end
                end
                ST_AFIN: begin
                    r_head  <= w_head_new;
                    r_count <= r_count - r_npop;
                    r_dup   <= w_dup;
                    r_abort <= 1'b0;
                    r_st    <= ST_STAT;
                    if (w_dup) begin
                        if (w_dupc_inc == 2'd3) begin
                            // Third duplicate in a row: fast retransmit.
                            r_cur  <= CC_FR;
                            r_dupc <= '0;
                            if (r_count != '0) begin
                                r_ss   <= w_ss_new;
                                r_cwnd <= w_ss_grow;
                                r_st   <= ST_FRSCAN;
                            end
                        end else begin
                            r_dupc <= w_dupc_inc;
                            if (r_cur != CC_DN) begin
                                r_prev <= r_cur;
                                r_cur  <= CC_DN;
                            end
                        end
                    end else begin
                        r_dupc <= '0;
                        unique case (w_restore)
                            CC_SS: begin
                                r_cwnd <= f_sat24({1'b0, r_cwnd} + {13'd0, r_mss});
                                r_cur  <= (f_sat24({1'b0, r_cwnd} + {13'd0, r_mss}) >= r_ss) ?
                                          CC_CA : CC_SS;
                            end
                            CC_FR: begin
                                r_cur <= CC_CA;
                            end
                            CC_CA: begin
                                r_cur <= CC_CA;
                                r_st  <= ST_DIV;
                            end
                            CC_DN: begin
                                r_cur <= CC_DN;
                            end
                        endcase
                    end
                end
                ST_FRSCAN: begin
                    if (r_pv && w_fr_emit) begin
                        if (w_fr_head) begin
                            r_abort <= 1'b1;
                        end else begin
                            r_sent[r_ps] <= 1'b1;
                        end
                    end
                    if (w_scan_done) begin
                        r_st <= ST_FRHEAD;
                    end
                end
                ST_FRHEAD: begin
                    r_st <= ST_STAT;
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_cwnd <= f_sat24({1'b0, r_cwnd} + {1'b0, w_div_rsp.quo});
                        r_st   <= ST_STAT;
                    end
                end
                ST_TSCAN: begin
                    // First pass only finds out whether any entry timed out, so that
                    // every result of the tick carries the final window values.
                    if (r_pv && !r_acked[r_ps] && r_sent[r_ps] && w_tout) begin
                        r_timed <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_st <= ST_TUPD;
                    end
                end
                ST_TUPD: begin
                    if (r_timed) begin
                        r_ss   <= w_ss_new;
                        r_cwnd <= {8'd0, r_init_cwnd};
                        r_cur  <= CC_SS;
                    end
                    r_st <= ST_TEMIT;
                end
                ST_TEMIT: begin
                    if (r_pv && w_t_emit) begin
                        r_sent[r_ps] <= 1'b1;
                    end
                    if (w_scan_done) begin
                        r_st <= ST_STAT;
                    end
                end
                ST_STAT: begin
                    r_st <= ST_IDLE;
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase

            // Register writes; the initial-window write also seeds cwnd, and the threshold write sets ssthresh.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INIT_CWND: begin
                        r_init_cwnd <= i_cfg_data[15:0];
                        r_cwnd      <= {8'd0, i_cfg_data[15:0]};
                    end
                    CFG_INIT_SS: begin
                        r_ss <= i_cfg_data;
                    end
                    CFG_MSS: begin
                        r_mss <= i_cfg_data[11:0];
                    end
                    CFG_RTO: begin
                        r_rto <= i_cfg_data[15:0];
                    end
                    CFG_START_SEQ: begin
                        r_next_seq <= w_cfg_seq17[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result registers: one strobed cycle per result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= w_emit;
        end
        if (w_emit) begin
            r_o_kind <= w_emit_kind;
            r_o_seq  <= w_emit_seq;
            r_o_len  <= w_emit_len;
            r_o_dup  <= w_emit_dup;
            r_o_last <= w_emit_last;
        end
    end

    tsw_mem #(
        .DEPTH (WINDOW_ENTRIES)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_dat_en (w_mem_dat_en),
        .i_wr_tim_en (w_mem_tim_en),
        .i_wr_addr   (w_mem_addr),
        .i_wr_seq    (r_next_seq),
        .i_wr_len    (i_seg_len),
        .i_wr_tim    (w_mem_tim),
        .i_rd_addr   (w_slot_i),
        .o_rd_seq    (w_rd_seq),
        .o_rd_len    (w_rd_len),
        .o_rd_tim    (w_rd_tim)
    );

    tsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Window values are stable for the whole of an item's result train.
    assign o_res_valid    = r_o_valid;
    assign o_result_kind  = r_o_kind;
    assign o_seq          = r_o_seq;
    assign o_len          = r_o_len;
    assign o_is_dup       = r_o_dup;
    assign o_last         = r_o_last;
    assign o_cwnd_out     = r_cwnd;
    assign o_ssthresh_out = r_ss;
    assign o_cc_state     = r_cur;
    assign o_window_pkts  = 5'(r_count);
    assign o_window_bytes = r_bytes;

endmodule

// ----- hdl/tsw_mem.sv -----
module tsw_mem #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_dat_en,
    input  logic                     i_wr_tim_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]              i_wr_seq,
    input  logic [11:0]              i_wr_len,
    input  logic [31:0]              i_wr_tim,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [15:0]              o_rd_seq,
    output logic [11:0]              o_rd_len,
    output logic [31:0]              o_rd_tim
);

    logic [27:0] r_dat [DEPTH];
    logic [31:0] r_tim [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_dat_en) begin
            r_dat[i_wr_addr] <= {i_wr_seq, i_wr_len};
        end
        if (i_wr_tim_en) begin
            r_tim[i_wr_addr] <= i_wr_tim;
        end
        {o_rd_seq, o_rd_len} <= r_dat[i_rd_addr];
        o_rd_tim             <= r_tim[i_rd_addr];
    end

endmodule

// ----- hdl/tsw_div.sv -----
module tsw_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tsw_pkg::t_div_req  i_req,
    output tsw_pkg::t_div_rsp  o_rsp
);

    import tsw_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [WIN_W-1:0] r_rem;
    logic [WIN_W-1:0] r_q;
    logic [WIN_W-1:0] r_den;
    logic [WIN_W:0]   w_sh;
    logic             w_ge;

    // One quotient bit per cycle, restoring form.
    assign w_sh = {r_rem, r_q[WIN_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(WIN_W - 1);
                r_rem  <= '0;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= w_ge ? WIN_W'(w_sh - {1'b0, r_den}) : w_sh[WIN_W-1:0];
                r_q   <= {r_q[WIN_W-2:0], w_ge};
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

// ----- hdl/tsw_chk.sv -----
module tsw_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_res_valid,
    input logic [2:0]  o_result_kind,
    input logic [15:0] o_seq,
    input logic [11:0] o_len,
    input logic        o_last
);

    import tsw_pkg::*;

    a_push_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == K_PUSH) |=>
            (o_res_valid && o_last &&
             (o_result_kind == RK_SEND || o_result_kind == RK_REFUSE)))
        else $error("push request not answered in the next cycle");

    a_long_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == K_ACK || i_kind == K_TICK)) |=> busy)
        else $error("ACK or tick request did not occupy the block");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_result_kind == RK_ACK || o_result_kind == RK_TICK)) |-> o_last)
        else $error("status result not marked as final");

    a_refuse_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result_kind == RK_REFUSE) |-> (o_seq == '0 && o_len == '0))
        else $error("refused push carries a segment");

endmodule

bind tcp_sender_window_congestion_core tsw_chk u_tsw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_kind        (i_kind),
    .o_res_valid   (o_res_valid),
    .o_result_kind (o_result_kind),
    .o_seq         (o_seq),
    .o_len         (o_len),
    .o_last        (o_last)
);
